// ===== hdl/cwh_pkg.sv =====
package cwh_pkg;

   localparam int DELTA_BINS_DEF = 64;
   localparam int MULT_BINS_DEF  = 20;
   localparam int TIME_BITS_DEF  = 48;
   localparam int COUNT_BITS_DEF = 32;

   localparam int BW_BITS        = 16;
   localparam int WL_BITS        = 32;
   localparam int BT_BITS        = 36;
   localparam int CSR_DATA_BITS  = 36;
   localparam int CSR_INDEX_BITS = 2;
   localparam int TS_BITS        = 48;
   localparam int OUT_COUNT_BITS = 32;
   localparam int HITCNT_BITS    = 8;

   localparam logic [WL_BITS-1:0] WL_RESET = 32'd5000;
   localparam logic [BT_BITS-1:0] BT_RESET = 36'd50000000000;
   localparam logic [BW_BITS-1:0] BW_RESET = 16'd20;

   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BACKWARD_TOL  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BIN_WIDTH     = 2'd2;

   localparam logic [3:0] SEL_DELTA_LAST = 4'd2;
   localparam logic [3:0] SEL_PAIR_FIRST = 4'd3;
   localparam logic [3:0] SEL_PAIR_LAST  = 4'd5;
   localparam logic [3:0] SEL_MULT_FIRST = 4'd6;
   localparam logic [3:0] SEL_MULT_LAST  = 4'd8;

   localparam logic [1:0] LAST_CHANNEL = 2'd2;

   typedef enum logic [1:0] {
      CMD_HIT   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_DELTA = 2'd0,
      KIND_PAIR  = 2'd1,
      KIND_MULT  = 2'd2
   } kind_type;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_CLEAR  = 12'b000000000010,
      ST_EVAL   = 12'b000000000100,
      ST_NEXT   = 12'b000000001000,
      ST_DIFF   = 12'b000000010000,
      ST_CLASS  = 12'b000000100000,
      ST_DIV    = 12'b000001000000,
      ST_ADDR   = 12'b000010000000,
      ST_RD     = 12'b000100000000,
      ST_WR     = 12'b001000000000,
      ST_UPDATE = 12'b010000000000,
      ST_DONE   = 12'b100000000000
   } state_type;

endpackage

// ===== hdl/cwh_div.sv =====
module cwh_div #(
   parameter int DVW = 24,
   parameter int QB  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DVW-1:0]               dividend,
   input  logic [cwh_pkg::BW_BITS-1:0]  divisor,
   output logic                         done,
   output logic [QB-1:0]                quotient
);
   import cwh_pkg::*;

   localparam int W  = DVW + QB;
   localparam int CW = $clog2(QB);

   logic [DVW-1:0] rem_ff, rem_in;
   logic [W-1:0]   dsh_ff, dsh_in;
   logic [QB-1:0]  q_ff, q_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic           ge;

   assign ge = W'(rem_ff) >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = W'(divisor) << (QB - 1);
         q_in    = '0;
         cnt_in  = CW'(QB - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = DVW'(W'(rem_ff) - dsh_ff);
            q_in   = {q_ff[QB-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QB-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== hdl/cwh_mem.sv =====
module cwh_mem #(
   parameter int DEPTH = 651,
   parameter int AW    = 10,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);
   import cwh_pkg::*;

   logic [DW-1:0] store_mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= wdata;
      end
      rdata_ff <= store_mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/coincidence_window_histogrammer.sv =====
// Three-channel coincidence histogrammer. One item is taken at a time and
// req_stall stays high until its result is loaded into the output register. A
// hit inside the window makes at most one delta fill (none when its timestamp
// equals the last hit on its channel); a hit that closes a window makes up to
// three multiplicity fills and, on a triple coincidence, three pair fills. A
// multiplicity fill is a read-modify-write of the bin store, which has one read
// and one write port; delta and pair fills first run the shared shift-subtract
// bin divider, one quotient bit per cycle (clog2(2*DELTA_BINS+1) bits, 8 at the
// defaults), except when the value lands in an edge bin. A read outside the
// store goes straight to its result. After reset and on every clear command the
// store of 9*DELTA_BINS+3*MULT_BINS+15 bins (651 at the defaults) is swept to
// zero, one bin per cycle, during which no item is taken. A result that waits
// on rsp_stall holds the block in its final state.
module coincidence_window_histogrammer #(
   parameter int DELTA_BINS = cwh_pkg::DELTA_BINS_DEF,
   parameter int MULT_BINS  = cwh_pkg::MULT_BINS_DEF,
   parameter int TIME_BITS  = cwh_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = cwh_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic [1:0]                          req_channel,
   input  logic [cwh_pkg::TS_BITS-1:0]         req_timestamp,
   input  logic [3:0]                          req_histogram_select,
   input  logic [7:0]                          req_bin_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cwh_pkg::OUT_COUNT_BITS-1:0]  rsp_bin_count,
   output logic                                rsp_window_closed,
   output logic                                rsp_triple_coincidence,
   output logic                                rsp_time_reversed,
   input  logic                                csr_we,
   input  logic [cwh_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cwh_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import cwh_pkg::*;

   localparam int DSZ   = DELTA_BINS + 2;
   localparam int PSZ   = 2 * DELTA_BINS + 2;
   localparam int MSZ   = MULT_BINS + 1;
   localparam int PBASE = 3 * DSZ;
   localparam int MBASE = PBASE + 3 * PSZ;
   localparam int TOTAL = MBASE + 3 * MSZ;
   localparam int AW    = $clog2(TOTAL);
   localparam int IW    = $clog2((PSZ > MSZ) ? PSZ : MSZ);
   localparam int SPW   = BW_BITS + $clog2(DELTA_BINS + 1);
   localparam int DVW   = SPW + 1;
   localparam int QB    = $clog2(2 * DELTA_BINS + 1);
   localparam int CMPW  = (TIME_BITS > BT_BITS) ? TIME_BITS : BT_BITS;

   state_type                 state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [1:0]                ch_ff, ch_in;
   logic [TIME_BITS-1:0]      ts_ff, ts_in;
   logic [WL_BITS-1:0]        wl_ff, wl_in;
   logic [BT_BITS-1:0]        bt_ff, bt_in;
   logic [BW_BITS-1:0]        bw_ff, bw_in;
   logic [TIME_BITS-1:0]      ws_ff, ws_in;
   logic [TIME_BITS-1:0]      last_ff [3];
   logic [TIME_BITS-1:0]      last_in [3];
   logic [HITCNT_BITS-1:0]    cnt_ff [3];
   logic [HITCNT_BITS-1:0]    cnt_in [3];
   logic                      rev_flag_ff, rev_flag_in;
   logic                      inside_ff, inside_in;
   logic                      res_closed_ff, res_closed_in;
   logic                      res_triple_ff, res_triple_in;
   logic                      res_rev_ff, res_rev_in;
   logic [COUNT_BITS-1:0]     res_count_ff, res_count_in;
   logic [2:0]                step_ff, step_in;
   kind_type                  kind_ff, kind_in;
   logic [1:0]                unit_ff, unit_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [TIME_BITS-1:0]      m_ff, m_in;
   logic                      neg_ff, neg_in;
   logic [SPW-1:0]            span_ff, span_in;
   logic [AW-1:0]             addr_ff, addr_in;
   logic [AW-1:0]             clr_addr_ff, clr_addr_in;
   logic                      clr_rsp_ff, clr_rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                      rsp_closed_ff, rsp_closed_in;
   logic                      rsp_triple_ff, rsp_triple_in;
   logic                      rsp_rev_ff, rsp_rev_in;

   logic [BW_BITS-1:0]        bw_eff;
   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic [COUNT_BITS-1:0]     mem_wdata;
   logic [COUNT_BITS-1:0]     mem_rdata;
   logic                      div_start;
   logic [DVW-1:0]            div_dividend;
   logic                      div_done;
   logic [QB-1:0]             div_q;

   logic                      ge;
   logic [TIME_BITS-1:0]      fwd;
   logic [TIME_BITS-1:0]      bwd;
   logic                      in_window;
   logic [TIME_BITS-1:0]      opa;
   logic [TIME_BITS-1:0]      opb;
   logic [TIME_BITS-1:0]      spanx;
   logic [1:0]                k;
   logic [AW-1:0]             addr_calc;

   assign bw_eff = (bw_ff == '0) ? BW_BITS'(1) : bw_ff;
   assign spanx  = TIME_BITS'(span_ff);
   assign k      = 2'(step_ff - 3'd1);

   assign ge        = ts_ff >= ws_ff;
   assign fwd       = ts_ff - ws_ff;
   assign bwd       = ws_ff - ts_ff;
   assign in_window = ge ? (CMPW'(fwd) < CMPW'(wl_ff)) : (CMPW'(bwd) < CMPW'(bt_ff));

   always_comb begin
      if (kind_ff == KIND_DELTA) begin
         opa = ts_ff;
         opb = last_ff[ch_ff];
      end else if (unit_ff == 2'd0) begin
         opa = last_ff[0];
         opb = last_ff[1];
      end else if (unit_ff == 2'd1) begin
         opa = last_ff[0];
         opb = last_ff[2];
      end else begin
         opa = last_ff[1];
         opb = last_ff[2];
      end
   end

   always_comb begin
      case (kind_ff)
         KIND_DELTA: addr_calc = AW'(unit_ff) * AW'(DSZ) + AW'(idx_ff);
         KIND_PAIR:  addr_calc = AW'(PBASE) + AW'(unit_ff) * AW'(PSZ) + AW'(idx_ff);
         KIND_MULT:  addr_calc = AW'(MBASE) + AW'(unit_ff) * AW'(MSZ) + AW'(idx_ff);
         default:    addr_calc = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ch_in         = ch_ff;
      ts_in         = ts_ff;
      wl_in         = wl_ff;
      bt_in         = bt_ff;
      bw_in         = bw_ff;
      ws_in         = ws_ff;
      last_in       = last_ff;
      cnt_in        = cnt_ff;
      rev_flag_in   = rev_flag_ff;
      inside_in     = inside_ff;
      res_closed_in = res_closed_ff;
      res_triple_in = res_triple_ff;
      res_rev_in    = res_rev_ff;
      res_count_in  = res_count_ff;
      step_in       = step_ff;
      kind_in       = kind_ff;
      unit_in       = unit_ff;
      idx_in        = idx_ff;
      m_in          = m_ff;
      neg_in        = neg_ff;
      span_in       = span_ff;
      addr_in       = addr_ff;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_closed_in = rsp_closed_ff;
      rsp_triple_in = rsp_triple_ff;
      rsp_rev_in    = rsp_rev_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = '0;
      div_start     = 1'b0;
      div_dividend  = '0;

      if (csr_we) begin
         case (csr_index)
            REG_WINDOW_LENGTH: wl_in = csr_wdata[WL_BITS-1:0];
            REG_BACKWARD_TOL:  bt_in = csr_wdata[BT_BITS-1:0];
            REG_BIN_WIDTH:     bw_in = csr_wdata[BW_BITS-1:0];
            default:           ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = cmd_type'(req_command);
               ch_in         = req_channel;
               ts_in         = TIME_BITS'(req_timestamp);
               res_closed_in = 1'b0;
               res_triple_in = 1'b0;
               res_rev_in    = 1'b0;
               res_count_in  = '0;
               step_in       = '0;
               span_in       = SPW'(bw_eff) * SPW'(DELTA_BINS);
               idx_in        = IW'(req_bin_index);
               state_in      = ST_DONE;
               case (cmd_type'(req_command))
                  CMD_HIT: begin
                     if (req_channel <= LAST_CHANNEL) begin
                        state_in = ST_EVAL;
                     end
                  end
                  CMD_READ: begin
                     if (req_histogram_select <= SEL_DELTA_LAST) begin
                        kind_in = KIND_DELTA;
                        unit_in = req_histogram_select[1:0];
                        if (32'(req_bin_index) < DSZ) begin
                           state_in = ST_ADDR;
                        end
                     end else if (req_histogram_select <= SEL_PAIR_LAST) begin
                        kind_in = KIND_PAIR;
                        unit_in = 2'(req_histogram_select - SEL_PAIR_FIRST);
                        if (32'(req_bin_index) < PSZ) begin
                           state_in = ST_ADDR;
                        end
                     end else if (req_histogram_select <= SEL_MULT_LAST) begin
                        kind_in = KIND_MULT;
                        unit_in = 2'(req_histogram_select - SEL_MULT_FIRST);
                        if (32'(req_bin_index) < MSZ) begin
                           state_in = ST_ADDR;
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     clr_rsp_in  = 1'b1;
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            if (clr_addr_ff == AW'(TOTAL - 1)) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_EVAL: begin
            inside_in     = in_window;
            res_rev_in    = in_window && !ge;
            res_closed_in = !in_window;
            res_triple_in = !in_window && !rev_flag_ff && cnt_ff[0] == HITCNT_BITS'(1)
                            && cnt_ff[1] == HITCNT_BITS'(1) && cnt_ff[2] == HITCNT_BITS'(1);
            state_in      = ST_NEXT;
         end
         ST_NEXT: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               3'd0: begin
                  kind_in = KIND_DELTA;
                  unit_in = ch_ff;
                  if (inside_ff && ts_ff != last_ff[ch_ff]) begin
                     step_in  = step_ff;
                     state_in = ST_DIFF;
                  end
               end
               3'd1, 3'd2, 3'd3: begin
                  kind_in = KIND_MULT;
                  unit_in = k;
                  idx_in  = (32'(cnt_ff[k]) >= MULT_BINS) ? IW'(MULT_BINS) : IW'(cnt_ff[k]);
                  if (!inside_ff && cnt_ff[k] != '0) begin
                     step_in  = step_ff;
                     state_in = ST_ADDR;
                  end
               end
               3'd4, 3'd5, 3'd6: begin
                  kind_in = KIND_PAIR;
                  unit_in = 2'(step_ff - 3'd4);
                  if (res_triple_ff) begin
                     step_in  = step_ff;
                     state_in = ST_DIFF;
                  end
               end
               default: state_in = ST_UPDATE;
            endcase
         end
         ST_DIFF: begin
            m_in     = (opa >= opb) ? opa - opb : opb - opa;
            neg_in   = opa < opb;
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            state_in = ST_DIV;
            if (kind_ff == KIND_DELTA) begin
               if (m_ff >= spanx) begin
                  idx_in   = IW'(DELTA_BINS + 1);
                  state_in = ST_ADDR;
               end else begin
                  div_dividend = DVW'(m_ff);
               end
            end else if (!neg_ff) begin
               if (m_ff >= spanx) begin
                  idx_in   = IW'(2 * DELTA_BINS + 1);
                  state_in = ST_ADDR;
               end else begin
                  div_dividend = DVW'(span_ff) + DVW'(m_ff);
               end
            end else begin
               if (m_ff > spanx) begin
                  idx_in   = '0;
                  state_in = ST_ADDR;
               end else begin
                  div_dividend = DVW'(span_ff) - DVW'(m_ff);
               end
            end
            div_start = (state_in == ST_DIV);
         end
         ST_DIV: begin
            if (div_done) begin
               idx_in   = IW'(div_q) + IW'(1);
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            addr_in  = addr_calc;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            if (cmd_ff == CMD_READ) begin
               res_count_in = mem_rdata;
               state_in     = ST_DONE;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
               step_in   = step_ff + 1'b1;
               state_in  = ST_NEXT;
            end
         end
         ST_UPDATE: begin
            if (inside_ff) begin
               if (res_rev_ff) begin
                  rev_flag_in = 1'b1;
               end
               if (cnt_ff[ch_ff] != '1) begin
                  cnt_in[ch_ff] = cnt_ff[ch_ff] + 1'b1;
               end
            end else begin
               rev_flag_in   = 1'b0;
               cnt_in[0]     = '0;
               cnt_in[1]     = '0;
               cnt_in[2]     = '0;
               cnt_in[ch_ff] = HITCNT_BITS'(1);
               ws_in         = ts_ff;
            end
            last_in[ch_ff] = ts_ff;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = OUT_COUNT_BITS'(res_count_ff);
               rsp_closed_in = res_closed_ff;
               rsp_triple_in = res_triple_ff;
               rsp_rev_in    = res_rev_ff;
               clr_rsp_in    = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ch_ff         <= ch_in;
      ts_ff         <= ts_in;
      inside_ff     <= inside_in;
      res_closed_ff <= res_closed_in;
      res_triple_ff <= res_triple_in;
      res_rev_ff    <= res_rev_in;
      res_count_ff  <= res_count_in;
      step_ff       <= step_in;
      kind_ff       <= kind_in;
      unit_ff       <= unit_in;
      idx_ff        <= idx_in;
      m_ff          <= m_in;
      neg_ff        <= neg_in;
      span_ff       <= span_in;
      addr_ff       <= addr_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_closed_ff <= rsp_closed_in;
      rsp_triple_ff <= rsp_triple_in;
      rsp_rev_ff    <= rsp_rev_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wl_ff        <= WL_RESET;
         bt_ff        <= BT_RESET;
         bw_ff        <= BW_RESET;
         ws_ff        <= '0;
         last_ff[0]   <= '0;
         last_ff[1]   <= '0;
         last_ff[2]   <= '0;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         cnt_ff[2]    <= '0;
         rev_flag_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         wl_ff        <= wl_in;
         bt_ff        <= bt_in;
         bw_ff        <= bw_in;
         ws_ff        <= ws_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rev_flag_ff  <= rev_flag_in;
      end
   end

   cwh_div #(
      .DVW (DVW),
      .QB  (QB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (bw_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   cwh_mem #(
      .DEPTH (TOTAL),
      .AW    (AW),
      .DW    (COUNT_BITS)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (addr_ff),
      .rdata (mem_rdata)
   );

   assign req_stall              = (state_ff != ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_bin_count          = rsp_count_ff;
   assign rsp_window_closed      = rsp_closed_ff;
   assign rsp_triple_coincidence = rsp_triple_ff;
   assign rsp_time_reversed      = rsp_rev_ff;

endmodule

// ===== bench/coincidence_window_histogrammer_test.sv =====
`timescale 1ns / 100ps

module coincidence_window_histogrammer_test;
   import cwh_pkg::*;

   localparam int NDELTA = DELTA_BINS_DEF + 2;
   localparam int NPAIR  = 2 * DELTA_BINS_DEF + 2;
   localparam int NMULT  = MULT_BINS_DEF + 1;
   localparam logic [63:0] TS_MASK = 64'hFFFF_FFFF_FFFF;
   localparam logic [31:0] BIN_FULL = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] bin_count;
      logic        window_closed;
      logic        triple_coincidence;
      logic        time_reversed;
   } outcome_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [1:0]  channel;
      logic [47:0] timestamp;
      logic [3:0]  hsel;
      logic [7:0]  bin;
      logic        typed;
      outcome_type want;
   } stim_row_type;

   localparam outcome_type ZERO = '{32'd0, 1'b0, 1'b0, 1'b0};
   localparam int NROWS = 24;

   stim_row_type stim_rows [0:NROWS-1] = '{
      '{CMD_READ,  2'd0, 48'd0, 4'd0,  8'd0,   1'b1, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd15, 8'd255, 1'b1, ZERO},
      '{CMD_NONE,  2'd3, 48'hFFFF_FFFF_FFFF, 4'd15, 8'd255, 1'b1, ZERO},
      '{CMD_HIT,   2'd3, 48'd100, 4'd0, 8'd0,  1'b1, ZERO},
      '{CMD_HIT,   2'd0, 48'd0,   4'd0, 8'd0,  1'b1, ZERO},
      '{CMD_HIT,   2'd1, 48'd10,  4'd0, 8'd0,  1'b0, ZERO},
      '{CMD_HIT,   2'd2, 48'd25,  4'd0, 8'd0,  1'b0, ZERO},
      '{CMD_HIT,   2'd0, 48'd6000, 4'd0, 8'd0, 1'b1, '{32'd0, 1'b1, 1'b1, 1'b0}},
      '{CMD_HIT,   2'd1, 48'd5990, 4'd0, 8'd0, 1'b1, '{32'd0, 1'b0, 1'b0, 1'b1}},
      '{CMD_HIT,   2'd2, 48'hFFFF_FFFF_FFFF, 4'd0, 8'd0, 1'b1,
        '{32'd0, 1'b1, 1'b0, 1'b0}},
      '{CMD_HIT,   2'd0, 48'd0,   4'd0, 8'd0,  1'b1, '{32'd0, 1'b1, 1'b0, 1'b0}},
      '{CMD_READ,  2'd0, 48'd0, 4'd6, 8'd1,    1'b0, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd3, 8'd64,   1'b0, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd4, 8'd64,   1'b0, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd5, 8'd64,   1'b0, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd0, 8'd65,   1'b0, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd1, 8'd65,   1'b0, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd2, 8'd66,   1'b1, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd8, 8'd21,   1'b1, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd5, 8'd129,  1'b0, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd9, 8'd0,    1'b1, ZERO},
      '{CMD_CLEAR, 2'd0, 48'd0, 4'd0, 8'd0,    1'b1, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd6, 8'd1,    1'b1, ZERO},
      '{CMD_READ,  2'd0, 48'd0, 4'd3, 8'd64,   1'b1, ZERO}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = '0;
   logic [1:0]  req_channel = '0;
   logic [47:0] req_timestamp = '0;
   logic [3:0]  req_histogram_select = '0;
   logic [7:0]  req_bin_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_bin_count;
   logic        rsp_window_closed;
   logic        rsp_triple_coincidence;
   logic        rsp_time_reversed;
   logic        csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   coincidence_window_histogrammer DUT (.*);

   // predictor state
   logic [63:0] win_length, back_tol, bin_w;
   logic [63:0] win_start;
   logic [63:0] last_hit [3];
   logic [7:0]  hits_in_win [3];
   logic        reversed_in_win;
   logic [31:0] delta_bins [3][NDELTA];
   logic [31:0] pair_bins [3][NPAIR];
   logic [31:0] mult_bins [3][NMULT];

   outcome_type pending_outcomes [$];
   int snd_idle = 32, rcv_idle = 87;
   int fails = 0, n_items = 0, n_closed = 0, n_triple = 0, n_rev = 0, n_reads = 0;
   logic hold_req = 1'b0, holding = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("** coincidence_window_histogrammer: FAILED **");
      $finish;
   end

   function automatic logic [31:0] bumped(logic [31:0] v);
      return (v == BIN_FULL) ? v : v + 32'd1;
   endfunction

   function automatic void wipe_bins();
      foreach (delta_bins[c, b]) delta_bins[c][b] = '0;
      foreach (pair_bins[c, b]) pair_bins[c][b] = '0;
      foreach (mult_bins[c, b]) mult_bins[c][b] = '0;
   endfunction

   function automatic void fill_gap(int c, logic [63:0] d);
      logic [63:0] bw, span, idx;
      bw = (bin_w == 0) ? 64'd1 : bin_w;
      span = DELTA_BINS_DEF * bw;
      idx = (d >= span) ? DELTA_BINS_DEF + 1 : 1 + d / bw;
      delta_bins[c][idx] = bumped(delta_bins[c][idx]);
   endfunction

   function automatic void fill_diff(int p, logic [63:0] a, logic [63:0] b);
      logic [63:0] bw, span, m, idx;
      bw = (bin_w == 0) ? 64'd1 : bin_w;
      span = DELTA_BINS_DEF * bw;
      if (a >= b) begin
         m = a - b;
         idx = (m >= span) ? 2 * DELTA_BINS_DEF + 1 : 1 + (span + m) / bw;
      end else begin
         m = b - a;
         idx = (m > span) ? 64'd0 : 1 + (span - m) / bw;
      end
      pair_bins[p][idx] = bumped(pair_bins[p][idx]);
   endfunction

   function automatic outcome_type predict_outcome(stim_row_type it);
      outcome_type o;
      logic [63:0] ts;
      logic in_win;
      int c, k, idx;
      o = ZERO;
      ts = {16'd0, it.timestamp};
      c = it.channel;
      if (it.cmd == CMD_READ) begin
         n_reads++;
         if (it.hsel <= SEL_DELTA_LAST && it.bin < NDELTA)
            o.bin_count = delta_bins[it.hsel][it.bin];
         else if (it.hsel >= SEL_PAIR_FIRST && it.hsel <= SEL_PAIR_LAST && it.bin < NPAIR)
            o.bin_count = pair_bins[it.hsel - SEL_PAIR_FIRST][it.bin];
         else if (it.hsel >= SEL_MULT_FIRST && it.hsel <= SEL_MULT_LAST && it.bin < NMULT)
            o.bin_count = mult_bins[it.hsel - SEL_MULT_FIRST][it.bin];
      end else if (it.cmd == CMD_CLEAR) begin
         wipe_bins();
      end else if (it.cmd == CMD_HIT && it.channel <= LAST_CHANNEL) begin
         if (ts >= win_start) in_win = (ts - win_start) < win_length;
         else in_win = (win_start - ts) < back_tol;
         if (in_win) begin
            if (ts < win_start) begin
               reversed_in_win = 1'b1;
               o.time_reversed = 1'b1;
               n_rev++;
            end
            if (ts > last_hit[c]) fill_gap(c, ts - last_hit[c]);
            else if (ts < last_hit[c]) fill_gap(c, last_hit[c] - ts);
            if (hits_in_win[c] != 8'hFF) hits_in_win[c]++;
         end else begin
            o.window_closed = 1'b1;
            n_closed++;
            for (k = 0; k < 3; k++)
               if (hits_in_win[k] != 0) begin
                  idx = (hits_in_win[k] >= MULT_BINS_DEF) ? MULT_BINS_DEF : hits_in_win[k];
                  mult_bins[k][idx] = bumped(mult_bins[k][idx]);
               end
            if (hits_in_win[0] == 1 && hits_in_win[1] == 1 && hits_in_win[2] == 1
                && !reversed_in_win) begin
               o.triple_coincidence = 1'b1;
               n_triple++;
               fill_diff(0, last_hit[0], last_hit[1]);
               fill_diff(1, last_hit[0], last_hit[2]);
               fill_diff(2, last_hit[1], last_hit[2]);
            end
            reversed_in_win = 1'b0;
            for (k = 0; k < 3; k++) hits_in_win[k] = 0;
            win_start = ts;
            hits_in_win[c] = 1;
         end
         last_hit[c] = ts;
      end
      return o;
   endfunction

   task automatic transfer_item(stim_row_type it);
      outcome_type o;
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= it.cmd;
      req_channel <= it.channel;
      req_timestamp <= it.timestamp;
      req_histogram_select <= it.hsel;
      req_bin_index <= it.bin;
      do @(posedge clock); while (req_stall);
      o = predict_outcome(it);
      pending_outcomes.push_back(it.typed ? it.want : o);
      n_items++;
   endtask

   task automatic write_csrs(logic [63:0] wl, logic [63:0] bt, logic [63:0] bw);
      csr_we <= 1'b1;
      csr_index <= REG_WINDOW_LENGTH;
      csr_wdata <= CSR_DATA_BITS'(wl);
      @(posedge clock);
      csr_index <= REG_BACKWARD_TOL;
      csr_wdata <= CSR_DATA_BITS'(bt);
      @(posedge clock);
      csr_index <= REG_BIN_WIDTH;
      csr_wdata <= CSR_DATA_BITS'(bw);
      @(posedge clock);
      csr_we <= 1'b0;
      win_length = wl & 64'hFFFF_FFFF;
      back_tol = bt & 64'hF_FFFF_FFFF;
      bin_w = bw & 64'hFFFF;
   endtask

   task automatic drain();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic stim_row_type hit_row(int c, logic [63:0] ts);
      stim_row_type r;
      r = '{CMD_HIT, 2'(c), 48'(ts), 4'($urandom_range(15)), 8'($urandom), 1'b0, ZERO};
      return r;
   endfunction

   // one well-formed window with random content
   task automatic send_window();
      logic [63:0] start, span, rmax;
      int order [3];
      int mode, k, extra;
      span = (win_length > 2000) ? 64'd2000 : win_length - 1;
      start = (win_start + win_length + $urandom_range(3000)) & TS_MASK;
      order = '{0, 1, 2};
      order.shuffle();
      mode = $urandom_range(9);
      transfer_item(hit_row(order[0], start));
      for (k = 1; k < 3; k++)
         if (mode != 9 || k == 1)
            transfer_item(hit_row(order[k], (start + $urandom_range(span)) & TS_MASK));
      if (mode >= 6) begin
         extra = $urandom_range(1, 3);
         for (k = 0; k < extra; k++)
            transfer_item(hit_row($urandom_range(2), (start + $urandom_range(span)) & TS_MASK));
      end
      if (mode == 5 && back_tol > 1 && start > 2000) begin
         rmax = (back_tol > 2000) ? 64'd2000 : back_tol - 1;
         transfer_item(hit_row($urandom_range(2), start - $urandom_range(1, rmax)));
      end
   endtask

   task automatic send_noise();
      stim_row_type r;
      int pick;
      pick = $urandom_range(99);
      r = '{CMD_HIT, 2'($urandom), {16'($urandom), 32'($urandom)},
            4'($urandom), 8'($urandom), 1'b0, ZERO};
      if (pick < 60) begin
         r.cmd = CMD_READ;
         r.hsel = 4'($urandom_range(8));
         r.bin = 8'((r.hsel <= SEL_DELTA_LAST) ? $urandom_range(NDELTA - 1)
                    : (r.hsel <= SEL_PAIR_LAST) ? $urandom_range(NPAIR - 1)
                    : $urandom_range(NMULT - 1));
      end else if (pick < 68) begin
         r.cmd = CMD_READ;
      end else if (pick < 74) begin
         r.cmd = CMD_CLEAR;
      end else if (pick < 80) begin
         r.cmd = CMD_NONE;
      end
      transfer_item(r);
   endtask

   initial begin
      wait (hold_req);
      @(posedge clock);
      holding <= 1'b1;
      repeat (400) @(posedge clock);
      holding <= 1'b0;
   end

   always @(posedge clock)
      rsp_stall <= holding || ($urandom_range(99) < rcv_idle);

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("transfer on rsp with nothing pending");
            fails++;
         end else begin
            e = pending_outcomes.pop_front();
            if (rsp_bin_count !== e.bin_count) begin
               $error("bin_count exp %0d got %0d", e.bin_count, rsp_bin_count);
               fails++;
            end
            if (rsp_window_closed !== e.window_closed) begin
               $error("window_closed exp %0d got %0d", e.window_closed, rsp_window_closed);
               fails++;
            end
            if (rsp_triple_coincidence !== e.triple_coincidence) begin
               $error("triple_coincidence exp %0d got %0d", e.triple_coincidence,
                      rsp_triple_coincidence);
               fails++;
            end
            if (rsp_time_reversed !== e.time_reversed) begin
               $error("time_reversed exp %0d got %0d", e.time_reversed, rsp_time_reversed);
               fails++;
            end
         end
      end
   end

   initial begin
      logic [63:0] wl_set [3], bt_set [3], bw_set [3];
      int p, target;
      wl_set = '{64'd1, 64'hFFFF_FFFF, 64'd4000};
      bt_set = '{64'd0, 64'hF_FFFF_FFFF, 64'd3000};
      bw_set = '{64'd0, 64'hFFFF, 64'd13};
      win_length = WL_RESET;
      back_tol = BT_RESET;
      bin_w = BW_RESET;
      win_start = '0;
      reversed_in_win = 1'b0;
      for (p = 0; p < 3; p++) begin
         last_hit[p] = '0;
         hits_in_win[p] = '0;
      end
      wipe_bins();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (stim_rows[i]) transfer_item(stim_rows[i]);
      for (p = 0; p < 3; p++) begin
         req_valid <= 1'b0;
         drain();
         if (p == 1) begin
            snd_idle = 87;
            rcv_idle = 32;
         end else if (p == 2) begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         write_csrs(wl_set[p], bt_set[p], bw_set[p]);
         if (p == 2) hold_req = 1'b1;
         target = n_items + 540;
         while (n_items < target)
            if ($urandom_range(99) < 75) send_window();
            else send_noise();
      end
      req_valid <= 1'b0;
      drain();
      $display("covered %0d transfers: %0d reads, %0d windows closed, %0d triples,",
               n_items, n_reads, n_closed, n_triple);
      $display("%0d reversed hits over three register settings and three idle patterns",
               n_rev);
      if (fails == 0)
         $display("** coincidence_window_histogrammer: PASSED **");
      else
         $display("** coincidence_window_histogrammer: FAILED **");
      $finish;
   end

endmodule
